// ----- design/ssh_pkg.sv -----
// package for the selectable string hash engine
// types, register codes and hash constants; no dependencies
package ssh_pkg;

  typedef enum logic [3:0] {
    MODE_RS    = 4'd0,
    MODE_JS    = 4'd1,
    MODE_PJW   = 4'd2,
    MODE_ELF   = 4'd3,
    MODE_BKDR  = 4'd4,
    MODE_SDBM  = 4'd5,
    MODE_DJB   = 4'd6,
    MODE_DEK   = 4'd7,
    MODE_AP    = 4'd8,
    MODE_DB    = 4'd9,
    MODE_PJWDB = 4'd10
  } hash_mode_t;

  localparam logic CFG_MODE = 1'b0;
  localparam logic CFG_BKDR = 1'b1;

  localparam logic [3:0]  MODE_RESET = 4'd10;
  localparam logic [31:0] BKDR_RESET = 32'd131;
  localparam logic [31:0] RS_STEP    = 32'd378551;
  localparam logic [31:0] RS_START   = 32'd63689;
  localparam logic [31:0] JS_START   = 32'd1315423911;
  localparam logic [31:0] DJB_START  = 32'd5381;
  localparam logic [31:0] PJW_HIGH   = 32'hF000_0000;
  localparam logic [31:0] M32        = 32'hFFFF_FFFF;

  localparam int QUEUE_DEPTH = 2;

  // one classified request as held in the queue
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_byte;
    logic        last_byte;
    logic        has_byte;
    logic [31:0] string_length;
  } ssh_item_t;

  // finished string handed to the result stage
  typedef struct packed {
    logic        valid;
    logic        pjwdb;
    logic [63:0] hash;
    logic [63:0] sum;
  } ssh_job_t;

endpackage

// ----- design/ssh_if.sv -----
// channel interfaces: input bytes, results and register writes
// depends on nothing
interface ssh_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        first_byte;
  logic        last_byte;
  logic        empty_string;
  logic [31:0] string_length;
  modport source (output valid, data_byte, first_byte, last_byte, empty_string,
                  string_length, input ready);
  modport sink (input valid, data_byte, first_byte, last_byte, empty_string,
                string_length, output ready);
endinterface

interface ssh_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash_value;
  modport source (output valid, hash_value, input ready);
  modport sink (input valid, hash_value, output ready);
endinterface

interface ssh_cfg_if;
  logic        valid;
  logic        ready;
  logic        reg_index;
  logic [31:0] wr_data;
  modport source (output valid, reg_index, wr_data, input ready);
  modport sink (input valid, reg_index, wr_data, output ready);
endinterface

// ----- design/ssh_front.sv -----
// front end: accepts input requests, classifies them and queues them
// depends on ssh_pkg
module ssh_front #(
  parameter int Depth = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_data_byte,
  input  logic                in_first_byte,
  input  logic                in_last_byte,
  input  logic                in_empty_string,
  input  logic [31:0]         in_string_length,
  input  logic                pop,
  output logic                q_valid,
  output ssh_pkg::ssh_item_t  q_item
);
  import ssh_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  ssh_item_t           mem_r [Depth];
  logic [PtrW-1:0]     wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]     count_r, count_nxt;
  logic                push, do_pop;
  ssh_item_t           item;

  assign in_ready = (count_r < CntW'(Depth));
  assign push     = in_valid && in_ready;
  assign q_valid  = (count_r != '0);
  assign do_pop   = pop && q_valid;
  assign q_item   = mem_r[rd_ptr_r];

  always_comb begin
    item.data_byte     = in_data_byte;
    item.first_byte    = in_first_byte;
    item.last_byte     = in_last_byte;
    item.has_byte      = !in_empty_string;
    item.string_length = in_string_length;
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + CntW'(push) - CntW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= item;
    end
  end
endmodule

// ----- design/ssh_core.sv -----
// back end: per-byte hash recurrence on the running state
// depends on ssh_pkg
module ssh_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic [3:0]          hash_mode,
  input  logic [31:0]         bkdr_multiplier,
  input  logic                q_valid,
  input  ssh_pkg::ssh_item_t  q_item,
  output logic                pop,
  output ssh_pkg::ssh_job_t   job
);
  import ssh_pkg::*;

  logic [63:0] hash_r, hash_nxt, sum_r, sum_nxt;
  logic [31:0] rsf_r, rsf_nxt;
  logic [1:0]  pos_r, pos_nxt;
  ssh_job_t    job_r, job_nxt;

  logic [63:0] h_base, s_base, c64, w, w1;
  logic [31:0] f_base, init, h32, c32, h1, mul_b, prod, h_new;
  logic [1:0]  p_base;
  logic [63:0] mul_full;
  logic        upd32;

  assign pop = q_valid && en;
  assign job = job_r;

  always_comb begin
    case (hash_mode)
      MODE_JS:  init = JS_START;
      MODE_DJB: init = DJB_START;
      MODE_DEK: init = q_item.string_length;
      default:  init = '0;
    endcase
    h_base = q_item.first_byte ? {32'd0, init} : hash_r;
    s_base = q_item.first_byte ? 64'd0 : sum_r;
    f_base = q_item.first_byte ? RS_START : rsf_r;
    p_base = q_item.first_byte ? 2'd0 : pos_r;
    h32    = h_base[31:0];
    c32    = {{24{q_item.data_byte[7]}}, q_item.data_byte};
    c64    = {{56{q_item.data_byte[7]}}, q_item.data_byte};
    mul_b  = (hash_mode == MODE_RS) ? f_base : bkdr_multiplier;
    mul_full = h32 * mul_b;
    prod   = mul_full[31:0];
    h1     = (h32 << 4) + c32;
    w      = (h_base << 4) + c64;
    w1     = (w[31:28] != 4'd0)
             ? ((w ^ {56'd0, w[31:28], 4'd0}) & {32'd0, ~PJW_HIGH}) : w;
    upd32  = 1'b1;
    h_new  = h32;
    unique case (hash_mode)
      MODE_RS:   h_new = prod + c32;
      MODE_JS:   h_new = h32 ^ ((h32 << 5) + c32 + (h32 >> 2));
      MODE_PJW,
      MODE_ELF:  h_new = (h1[31:28] != 4'd0)
                         ? ((h1 ^ {24'd0, h1[31:28], 4'd0}) & ~PJW_HIGH) : h1;
      MODE_BKDR: h_new = prod + c32;
      MODE_SDBM: h_new = c32 + (h32 << 6) + (h32 << 16) - h32;
      MODE_DJB:  h_new = (h32 << 5) + h32 + c32;
      MODE_DEK:  h_new = ((h32 << 5) ^ (h32 >> 27)) ^ c32;
      MODE_AP:   h_new = p_base[0] ? (h32 ^ ~((h32 << 11) ^ c32 ^ (h32 >> 5)))
                                   : (h32 ^ ((h32 << 7) ^ c32 ^ (h32 >> 3)));
      MODE_DB:   h_new = ((p_base == 2'd0) ? (h32 << 1) : h32) + c32;
      default:   upd32 = 1'b0;
    endcase

    hash_nxt = h_base;
    sum_nxt  = s_base;
    rsf_nxt  = f_base;
    pos_nxt  = p_base;
    if (q_item.has_byte) begin
      pos_nxt = p_base + 2'd1;
      if (hash_mode == MODE_PJWDB) begin
        hash_nxt = w1;
        sum_nxt  = ((p_base == 2'd0) ? (s_base << 1) : s_base) + c64;
      end else if (upd32) begin
        hash_nxt = {32'd0, h_new};
      end
      if (hash_mode == MODE_RS) begin
        rsf_nxt = f_base * RS_STEP;
      end
    end

    job_nxt.valid = pop && q_item.last_byte;
    job_nxt.pjwdb = (hash_mode == MODE_PJWDB);
    job_nxt.hash  = hash_nxt;
    job_nxt.sum   = sum_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r      <= '0;
      sum_r       <= '0;
      rsf_r       <= RS_START;
      pos_r       <= '0;
      job_r.valid <= 1'b0;
    end else if (en) begin
      if (pop) begin
        hash_r <= hash_nxt;
        sum_r  <= sum_nxt;
        rsf_r  <= rsf_nxt;
        pos_r  <= pos_nxt;
      end
      job_r.valid <= job_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      job_r.pjwdb <= job_nxt.pjwdb;
      job_r.hash  <= job_nxt.hash;
      job_r.sum   <= job_nxt.sum;
    end
  end
endmodule

// ----- design/ssh_final.sv -----
// result stage: 64-bit product from partial products and output register
// depends on ssh_pkg
module ssh_final (
  input  logic               clk,
  input  logic               rst_n,
  input  ssh_pkg::ssh_job_t  job,
  output logic               en,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [63:0]        out_hash_value
);
  import ssh_pkg::*;

  logic        b_valid_r, b_pj_r, out_valid_r;
  logic [63:0] p_ll_r, p_ll_nxt;
  logic [31:0] p_lh_r, p_hl_r, h_lo_r;
  logic [63:0] p_lh_full, p_hl_full;
  logic [63:0] out_r, out_nxt;

  assign en        = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_hash_value = out_r;

  always_comb begin
    p_ll_nxt  = job.sum[31:0] * job.hash[31:0];
    p_lh_full = job.sum[31:0] * job.hash[63:32];
    p_hl_full = job.sum[63:32] * job.hash[31:0];
    out_nxt   = b_pj_r ? (p_ll_r + {p_lh_r + p_hl_r, 32'd0}) : {32'd0, h_lo_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      b_valid_r   <= job.valid;
      out_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_ll_r <= p_ll_nxt;
      p_lh_r <= p_lh_full[31:0];
      p_hl_r <= p_hl_full[31:0];
      h_lo_r <= job.hash[31:0];
      b_pj_r <= job.pjwdb;
      out_r  <= out_nxt;
    end
  end
endmodule

// ----- design/selectable_string_hash_engine.sv -----
// selectable string hash engine, one string byte per request
// path to the result: queue write at the accepting edge, then recurrence and job register,
//   product stage, output register
// throughput: one request per cycle; a stalled result stalls the back end and the
//   two-entry queue then fills before in ready drops
// reset: synchronous active low; mode 10, multiplier 131, hash state cleared
module selectable_string_hash_engine #(
  parameter int QueueDepth = ssh_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  ssh_in_if.sink         in_ch,
  ssh_out_if.source      out_ch,
  ssh_cfg_if.sink        cfg_ch
);
  import ssh_pkg::*;

  logic [3:0]  mode_r;
  logic [31:0] bkdr_r;
  logic        q_valid, pop, en;
  ssh_item_t   q_item;
  ssh_job_t    job;

  // register writes are always taken
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_RESET;
      bkdr_r <= BKDR_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.reg_index)
        CFG_MODE: mode_r <= cfg_ch.wr_data[3:0];
        CFG_BKDR: bkdr_r <= cfg_ch.wr_data;
        default:  mode_r <= mode_r;
      endcase
    end
  end

  // front: take and classify requests into the queue
  ssh_front #(.Depth(QueueDepth)) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .in_data_byte     (in_ch.data_byte),
    .in_first_byte    (in_ch.first_byte),
    .in_last_byte     (in_ch.last_byte),
    .in_empty_string  (in_ch.empty_string),
    .in_string_length (in_ch.string_length),
    .pop              (pop),
    .q_valid          (q_valid),
    .q_item           (q_item)
  );

  // back: running hash recurrence, one byte per cycle while the result is not stalled
  ssh_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .en              (en),
    .hash_mode       (mode_r),
    .bkdr_multiplier (bkdr_r),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .pop             (pop),
    .job             (job)
  );

  // result: combined product for the pjw-db mode, then output register
  ssh_final u_final (
    .clk            (clk),
    .rst_n          (rst_n),
    .job            (job),
    .en             (en),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_hash_value (out_ch.hash_value)
  );

  // back end holds while the result waits
  a_stall_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |-> !pop)
    else $error("queue popped while result stalled");

  // never pop an empty queue
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid)
    else $error("pop from empty queue");

  // a finished string taken while the back end advances is captured in the product stage register
  a_job_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
    (job.valid && en && !(out_ch.valid && !out_ch.ready)) |=> (u_final.b_valid_r == 1'b1))
    else $error("finished string lost");
endmodule

// ----- sim/ssh_tb_if.sv -----
`timescale 1ns / 1ps
// testbench-side note: channel interfaces come from the design (ssh_if.sv)
// this file holds the small stimulus record shared by the testbench top
// depends on nothing
package ssh_tb_pkg;
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_byte;
    logic        last_byte;
    logic        empty_string;
    logic [31:0] string_length;
  } req_t;
endpackage

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// self-checking bench for the selectable string hash engine
// drives byte requests and register writes, predicts hashes, checks results
// depends on ssh_pkg, ssh_tb_pkg and the design's channel interfaces
module testbench;
  import ssh_pkg::*;
  import ssh_tb_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ssh_in_if  in_ch ();
  ssh_out_if out_ch ();
  ssh_cfg_if cfg_ch ();

  selectable_string_hash_engine dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  // predictor state, mirrors the engine's registers
  logic [3:0]  mode_q;
  logic [31:0] mult_q;
  logic [63:0] hash_acc;
  logic [63:0] sum_acc;
  logic [31:0] rs_mul;
  logic [1:0]  pos_q;

  req_t        pending_reqs[$];
  logic [63:0] expected_hashes[$];
  int          errors = 0;
  int          sent_count = 0;
  int          src_idle_pct = 0;
  int          snk_stall_pct = 0;
  longint      cycles = 0;
  bit          hold_off = 1'b0;

  // fold one byte into the running hash for the current mode
  function automatic void fold_byte(input logic [7:0] b);
    logic [31:0] c;
    logic [63:0] c64, w, tw;
    logic [31:0] h, t;
    logic        blk;
    c = {{24{b[7]}}, b};
    c64 = {{56{b[7]}}, b};
    h = hash_acc[31:0];
    blk = (pos_q == 2'd0);
    case (mode_q)
      MODE_RS: begin
        h = h * rs_mul + c;
        rs_mul = rs_mul * RS_STEP;
      end
      MODE_JS:   h ^= (h << 5) + c + (h >> 2);
      MODE_PJW: begin
        h = (h << 4) + c;
        t = h & PJW_HIGH;
        if (t != 0) h = (h ^ (t >> 24)) & ~PJW_HIGH;
      end
      MODE_ELF: begin
        h = (h << 4) + c;
        t = h & PJW_HIGH;
        if (t != 0) begin
          h ^= t >> 24;
          h &= ~t;
        end
      end
      MODE_BKDR: h = h * mult_q + c;
      MODE_SDBM: h = c + (h << 6) + (h << 16) - h;
      MODE_DJB:  h = (h << 5) + h + c;
      MODE_DEK:  h = ((h << 5) ^ (h >> 27)) ^ c;
      MODE_AP: begin
        if (!pos_q[0]) h ^= (h << 7) ^ c ^ (h >> 3);
        else h ^= ~((h << 11) ^ c ^ (h >> 5));
      end
      MODE_DB: begin
        if (blk) h = h << 1;
        h += c;
      end
      default: ;
    endcase
    if (mode_q == MODE_PJWDB) begin
      w = (hash_acc << 4) + c64;
      tw = w & {32'd0, PJW_HIGH};
      if (tw != 0) w = (w ^ (tw >> 24)) & {32'd0, ~PJW_HIGH};
      hash_acc = w;
      if (blk) sum_acc = sum_acc << 1;
      sum_acc += c64;
    end else if (mode_q <= MODE_DB) begin
      hash_acc = {32'd0, h};
    end
    pos_q = pos_q + 2'd1;
  endfunction

  // advance the model by one accepted request, queue the hash on last byte
  function automatic void predict_hash(input req_t r);
    if (r.first_byte) begin
      case (mode_q)
        MODE_JS:  hash_acc = {32'd0, JS_START};
        MODE_DJB: hash_acc = {32'd0, DJB_START};
        MODE_DEK: hash_acc = {32'd0, r.string_length};
        default:  hash_acc = 64'd0;
      endcase
      sum_acc = 64'd0;
      rs_mul = RS_START;
      pos_q = 2'd0;
    end
    if (!r.empty_string) fold_byte(r.data_byte);
    if (r.last_byte) begin
      if (mode_q == MODE_PJWDB) expected_hashes.push_back(sum_acc * hash_acc);
      else expected_hashes.push_back({32'd0, hash_acc[31:0]});
    end
  endfunction

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // request driver: presents queued requests, idles at random
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_hash(pending_reqs.pop_front());
        sent_count <= sent_count + 1;
      end
      // valid is decided once per edge so it never toggles within a step
      if ((!in_ch.valid || in_ch.ready) ) begin
        if (pending_reqs.size() > ((in_ch.valid && in_ch.ready) ? 0 : 0) && !hold_off
            && $urandom_range(99) >= src_idle_pct) begin
          in_ch.valid <= 1'b1;
          in_ch.data_byte <= pending_reqs[0].data_byte;
          in_ch.first_byte <= pending_reqs[0].first_byte;
          in_ch.last_byte <= pending_reqs[0].last_byte;
          in_ch.empty_string <= pending_reqs[0].empty_string;
          in_ch.string_length <= pending_reqs[0].string_length;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: compares each result with the oldest prediction
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_hashes.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h",
                   $time, out_ch.hash_value);
          errors++;
        end else begin
          if (out_ch.hash_value !== expected_hashes[0]) begin
            $display("%0t: hash_value mismatch, expected %h, actual %h (mode %0d)",
                     $time, expected_hashes[0], out_ch.hash_value, mode_q);
            errors++;
          end
          void'(expected_hashes.pop_front());
        end
      end
      out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // one string of random content; well-formed, or broken if broken is set
  task automatic add_string(input int len, input bit broken);
    req_t r;
    int   i;
    for (i = 0; i < len; i++) begin
      r.data_byte = 8'($urandom_range(255));
      r.first_byte = (i == 0);
      r.last_byte = (i == len - 1);
      r.empty_string = 1'b0;
      r.string_length = ($urandom_range(3) == 0) ? $urandom : 32'(len);
      if (broken) begin
        r.first_byte = $urandom_range(3) == 0;
        r.last_byte = $urandom_range(3) == 0;
        r.empty_string = $urandom_range(5) == 0;
      end
      pending_reqs.push_back(r);
    end
  endtask

  task automatic add_req(input logic [7:0] b, input bit f, input bit l, input bit e,
                         input logic [31:0] len);
    pending_reqs.push_back('{b, f, l, e, len});
  endtask

  // wait until stimulus and results drain, then let the pipe settle
  task automatic drain();
    wait (pending_reqs.size() == 0 && !in_ch.valid);
    wait (expected_hashes.size() == 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wr_data <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    if (idx == CFG_MODE) mode_q = v[3:0];
    else mult_q = v;
  endtask

  // timeout guard
  always @(posedge clk) begin
    if (cycles > 400000) begin
      $display("selectable_string_hash_engine verification failed");
      $finish;
    end
  end

  initial begin
    int ph, m, n;
    logic [31:0] mults[4];
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.first_byte = 1'b0;
    in_ch.last_byte = 1'b0;
    in_ch.empty_string = 1'b0;
    in_ch.string_length = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.reg_index = CFG_MODE;
    cfg_ch.wr_data = '0;
    mode_q = MODE_RESET;
    mult_q = BKDR_RESET;
    hash_acc = '0;
    sum_acc = '0;
    rs_mul = RS_START;
    pos_q = '0;
    mults = '{32'd0, 32'hFFFF_FFFF, 32'd131, 32'd65599};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: bytes without a start after reset, then extremes in reset mode
    add_req(8'h7F, 1'b0, 1'b0, 1'b0, 32'd0);
    add_req(8'h80, 1'b0, 1'b1, 1'b0, 32'd0);
    add_req(8'h00, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);  // empty string
    add_req(8'hFF, 1'b1, 1'b0, 1'b0, 32'hFFFF_FFFF);
    for (n = 0; n < 9; n++) add_req(8'hF0 ^ n[7:0], 1'b0, n == 8, 1'b0, 32'd0);
    add_req(8'h55, 1'b1, 1'b1, 1'b0, 32'd1);
    drain();
    // mode change inside a string
    write_reg(CFG_MODE, {28'd0, MODE_DJB});
    add_req(8'h41, 1'b1, 1'b0, 1'b0, 32'd3);
    drain();
    write_reg(CFG_MODE, {28'd0, MODE_RS});
    add_req(8'hC3, 1'b0, 1'b0, 1'b0, 32'd0);
    add_req(8'h00, 1'b0, 1'b0, 1'b1, 32'd0);
    add_req(8'h12, 1'b0, 1'b1, 1'b0, 32'd0);
    drain();

    // phases: every mode including unassigned ones, several multipliers
    for (ph = 0; ph < 32; ph++) begin
      m = ph % 16;
      case ((ph / 4) % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 51; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 51; end
        default: begin src_idle_pct = 33; snk_stall_pct = 33; end
      endcase
      write_reg(CFG_MODE, {28'd0, m[3:0]});
      write_reg(CFG_BKDR, (ph < 4) ? mults[ph] : $urandom);
      for (n = 0; n < 5; n++) begin
        if ($urandom_range(9) == 0) add_string($urandom_range(1, 6), 1'b1);
        else if ($urandom_range(9) == 0) add_req(8'($urandom), 1'b1, 1'b1, 1'b1, $urandom);
        else add_string($urandom_range(1, 8), 1'b0);
      end
      // sender holds off mid-stream until all results are back
      if (ph == 10) begin
        repeat (20) @(posedge clk);
        hold_off = 1'b1;
        @(posedge clk);
        wait (!in_ch.valid);
        wait (expected_hashes.size() == 0);
        repeat (10) @(posedge clk);
        hold_off = 1'b0;
      end
      drain();
    end
    write_reg(CFG_MODE, {28'd0, MODE_PJWDB});
    write_reg(CFG_BKDR, 32'hFFFF_FFFF);
    src_idle_pct = 0;
    snk_stall_pct = 0;
    add_string(40, 1'b0);
    drain();

    if (errors == 0) begin
      $display("selectable_string_hash_engine verification clean");
    end else begin
      $display("selectable_string_hash_engine verification failed");
    end
    $finish;
  end
endmodule
